// ----- src/pwm_input_duty_meter_unit_defines.svh -----
// ---------------------------------------------------------------------------
// PWM duty meter assertion macros
// Shared same-cycle implication and next-cycle checks for the duty meter.
// ---------------------------------------------------------------------------
`ifndef PWM_INPUT_DUTY_METER_UNIT_DEFINES_SVH
`define PWM_INPUT_DUTY_METER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwm duty meter check failed");

// antecedent implies consequent in the next cycle
`define PDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwm duty meter check failed");

`endif

// ----- src/pwm_dm_pkg.sv -----
// ---------------------------------------------------------------------------
// PWM duty meter package
// Widths, codes, state type and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package pwm_dm_pkg;

    localparam int DUTY_W = 10;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = CNT_W + 1;
    // high_width*1000 + sum/2 stays below 2^26
    localparam int NUM_W  = 26;
    localparam int DEN_W  = SUM_W;

    localparam logic [DUTY_W-1:0] FULL_SCALE = 10'd1000;

    localparam logic [1:0] KIND_EDGE    = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    localparam int SEEN_LOW_BIT  = 0;
    localparam int SEEN_HIGH_BIT = 1;

    typedef enum logic [1:0] {
        PH_UNKNOWN = 2'd0,
        PH_LOW     = 2'd1,
        PH_HIGH    = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_MEAS,
        ST_MDIV,
        ST_WRITE,
        ST_WALK,
        ST_TRIM,
        ST_TMUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic apply_item;
        logic cnt_clr;
        logic seed_wr;
        logic seed_done;
        logic meas_div_start;
        logic meas_take_fixed;
        logic meas_take_div;
        logic hist_wr;
        logic walk_step;
        logic trim_load;
        logic trim_take;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seeded;
        logic ready;
        logic stuck;
        logic sum_zero;
        logic slot_last;
        logic cnt_last;
        logic walk_end;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ----- src/pwm_input_duty_meter_unit.sv -----
// ---------------------------------------------------------------------------
// PWM input duty meter
// Measures PWM high-time duty in permille with a trimmed-mean history filter.
//
//   channel  direction  handshake              payload
//   in       slave      i_in_valid/o_in_stall  i_kind, i_pin_level,
//                                              i_capture_count
//   out      master     o_out_valid/i_out_stall o_duty_permille,
//                                              o_measurement_pending
//
// Edge, timeout, reserved and idle compute transactions go from idle to done.
// A pending measurement adds a 26-step serial divide (skipped when stuck or
// zero-width), a handoff and a write; the first compute adds HISTORY_DEPTH
// seeding writes, and a ring wrap adds a history walk and reciprocal scaling.
// A full output register holds the controller. Reset is synchronous; history
// is seeded by the first compute.
// ---------------------------------------------------------------------------
module pwm_input_duty_meter_unit #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic                          i_pin_level,
    input  logic [pwm_dm_pkg::CNT_W-1:0]  i_capture_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pwm_dm_pkg::DUTY_W-1:0] o_duty_permille,
    output logic                          o_measurement_pending
);

    pwm_dm_pkg::t_cmd  cmd;
    pwm_dm_pkg::t_stat stat;

    pwm_dm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pwm_dm_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_kind                (i_kind),
        .i_pin_level           (i_pin_level),
        .i_capture_count       (i_capture_count),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_duty_permille       (o_duty_permille),
        .o_measurement_pending (o_measurement_pending)
    );

endmodule

// ----- src/pwm_dm_ram.sv -----
// ---------------------------------------------------------------------------
// PWM duty meter RAM
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module pwm_dm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/pwm_dm_div.sv -----
// ---------------------------------------------------------------------------
// PWM duty meter divider
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per divide.
// ---------------------------------------------------------------------------
module pwm_dm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pwm_dm_pkg::NUM_W-1:0] i_numer,
    input  logic [pwm_dm_pkg::DEN_W-1:0] i_denom,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [pwm_dm_pkg::NUM_W-1:0] o_quot
);

    localparam int NW = pwm_dm_pkg::NUM_W;
    localparam int DW = pwm_dm_pkg::DEN_W;
    localparam int IW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= IW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == IW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_denom;
            r_quo <= i_numer;
        end else if (r_busy) begin
            // remainder stays below the divisor, so DW bits hold it
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- src/pwm_dm_ctrl.sv -----
// ---------------------------------------------------------------------------
// PWM duty meter controller
// Sequences item handling, seeding, measurement divide, history walk and
// trimmed-mean scaling.
// ---------------------------------------------------------------------------
module pwm_dm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_kind,
    output logic              o_in_stall,
    input  pwm_dm_pkg::t_stat i_stat,
    output pwm_dm_pkg::t_cmd  o_cmd
);

    pwm_dm_pkg::t_state r_state;
    pwm_dm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwm_dm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pwm_dm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == pwm_dm_pkg::KIND_COMPUTE) begin
                        if (!i_stat.seeded) begin
                            n_state = pwm_dm_pkg::ST_SEED;
                        end else if (i_stat.ready) begin
                            n_state = pwm_dm_pkg::ST_MEAS;
                        end else begin
                            n_state = pwm_dm_pkg::ST_DONE;
                        end
                    end else begin
                        n_state = pwm_dm_pkg::ST_DONE;
                    end
                end
            end
            pwm_dm_pkg::ST_SEED: begin
                if (i_stat.cnt_last) begin
                    n_state = i_stat.ready ? pwm_dm_pkg::ST_MEAS : pwm_dm_pkg::ST_DONE;
                end
            end
            pwm_dm_pkg::ST_MEAS: begin
                if (i_stat.stuck || i_stat.sum_zero) begin
                    n_state = pwm_dm_pkg::ST_WRITE;
                end else begin
                    n_state = pwm_dm_pkg::ST_MDIV;
                end
            end
            pwm_dm_pkg::ST_MDIV: begin
                if (i_stat.div_done) begin
                    n_state = pwm_dm_pkg::ST_WRITE;
                end
            end
            pwm_dm_pkg::ST_WRITE: begin
                n_state = i_stat.slot_last ? pwm_dm_pkg::ST_WALK : pwm_dm_pkg::ST_DONE;
            end
            pwm_dm_pkg::ST_WALK: begin
                if (i_stat.walk_end) begin
                    n_state = pwm_dm_pkg::ST_TRIM;
                end
            end
            pwm_dm_pkg::ST_TRIM: begin
                n_state = pwm_dm_pkg::ST_TMUL;
            end
            pwm_dm_pkg::ST_TMUL: begin
                n_state = pwm_dm_pkg::ST_DONE;
            end
            pwm_dm_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = pwm_dm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pwm_dm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            pwm_dm_pkg::ST_IDLE: begin
                o_cmd.apply_item = i_in_valid;
                o_cmd.cnt_clr    = i_in_valid;
            end
            pwm_dm_pkg::ST_SEED: begin
                o_cmd.seed_wr   = 1'b1;
                o_cmd.seed_done = i_stat.cnt_last;
            end
            pwm_dm_pkg::ST_MEAS: begin
                if (i_stat.stuck || i_stat.sum_zero) begin
                    o_cmd.meas_take_fixed = 1'b1;
                end else begin
                    o_cmd.meas_div_start = 1'b1;
                end
            end
            pwm_dm_pkg::ST_MDIV: begin
                o_cmd.meas_take_div = i_stat.div_done;
            end
            pwm_dm_pkg::ST_WRITE: begin
                o_cmd.hist_wr = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            pwm_dm_pkg::ST_WALK: begin
                o_cmd.walk_step = 1'b1;
            end
            pwm_dm_pkg::ST_TRIM: begin
                o_cmd.trim_load = 1'b1;
            end
            pwm_dm_pkg::ST_TMUL: begin
                o_cmd.trim_take = 1'b1;
            end
            pwm_dm_pkg::ST_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_in_stall = (r_state != pwm_dm_pkg::ST_IDLE);

endmodule

// ----- src/pwm_dm_dp.sv -----
// ---------------------------------------------------------------------------
// PWM duty meter datapath
// Phase machine state, history RAM, measurement divider, walk accumulator,
// trimmed-mean scaling and output register.
// ---------------------------------------------------------------------------
`include "pwm_input_duty_meter_unit_defines.svh"

module pwm_dm_dp #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pwm_dm_pkg::t_cmd                  i_cmd,
    output pwm_dm_pkg::t_stat                 o_stat,
    input  logic [1:0]                        i_kind,
    input  logic                              i_pin_level,
    input  logic [pwm_dm_pkg::CNT_W-1:0]      i_capture_count,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [pwm_dm_pkg::DUTY_W-1:0]     o_duty_permille,
    output logic                              o_measurement_pending
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int DW     = pwm_dm_pkg::DUTY_W;
    localparam int TRIM_N = HISTORY_DEPTH - 2;
    localparam int TSUM_W = $clog2(HISTORY_DEPTH * 1000 + 1);
    // divide by TRIM_N as a multiply by the rounded-up reciprocal; the shift
    // is wide enough that the quotient is exact over the whole sum range
    localparam int TRIM_S  = TSUM_W + $clog2(TRIM_N);
    localparam int TRIM_MW = TSUM_W + 1;
    localparam int TRIM_M  = ((1 << TRIM_S) + TRIM_N - 1) / TRIM_N;
    localparam int PROD_W  = TSUM_W + TRIM_MW;

    // item state
    pwm_dm_pkg::t_phase          r_phase, n_phase;
    logic [1:0]                  r_seen, n_seen;
    logic [pwm_dm_pkg::CNT_W-1:0] r_low_w, n_low_w;
    logic [pwm_dm_pkg::CNT_W-1:0] r_high_w, n_high_w;
    logic                        r_stuck_lo, n_stuck_lo;
    logic                        r_stuck_hi, n_stuck_hi;
    logic                        r_ready, n_ready;

    logic                        r_seeded;
    logic                        r_seed_item;
    logic                        r_pin;
    logic [AW-1:0]               r_slot;
    logic [DW-1:0]               r_filt;
    logic [DW-1:0]               r_duty;
    logic [CW-1:0]               r_cnt;
    logic [TSUM_W-1:0]           r_tsum;
    logic [DW-1:0]               r_lo;
    logic [DW-1:0]               r_hi;
    logic [TSUM_W-1:0]           r_trim_sum;

    logic                        r_out_valid;
    logic [DW-1:0]               r_out_duty;
    logic                        r_out_pend;

    logic [DW-1:0]               seed_val;
    logic [pwm_dm_pkg::SUM_W-1:0] width_sum;
    logic [pwm_dm_pkg::NUM_W-1:0] meas_numer;
    logic [TSUM_W-1:0]           trim_sum;
    logic [PROD_W-1:0]           trim_prod;
    logic [pwm_dm_pkg::NUM_W-1:0] div_quot;
    logic                        div_busy;
    logic                        div_done;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [DW-1:0]               ram_wr_data;
    logic                        ram_rd_en;
    logic [DW-1:0]               ram_rd_data;
    logic                        edge_item;
    logic                        out_free;

    assign seed_val  = r_pin ? pwm_dm_pkg::FULL_SCALE : '0;
    assign width_sum = {1'b0, r_high_w} + {1'b0, r_low_w};
    assign edge_item = i_cmd.apply_item && (i_kind == pwm_dm_pkg::KIND_EDGE) && !r_ready;

    // phase machine and stuck detection
    always_comb begin
        n_phase    = r_phase;
        n_seen     = r_seen;
        n_low_w    = r_low_w;
        n_high_w   = r_high_w;
        n_stuck_lo = r_stuck_lo;
        n_stuck_hi = r_stuck_hi;
        n_ready    = r_ready;
        if (edge_item) begin
            case (r_phase)
                pwm_dm_pkg::PH_LOW: begin
                    if (i_pin_level) begin
                        n_seen[pwm_dm_pkg::SEEN_LOW_BIT] = 1'b1;
                        n_low_w = i_capture_count;
                        n_phase = pwm_dm_pkg::PH_HIGH;
                    end else begin
                        n_seen     = '0;
                        n_stuck_lo = 1'b1;
                        n_ready    = 1'b1;
                    end
                end
                pwm_dm_pkg::PH_HIGH: begin
                    if (!i_pin_level) begin
                        n_seen[pwm_dm_pkg::SEEN_HIGH_BIT] = 1'b1;
                        n_high_w = i_capture_count;
                        n_phase  = pwm_dm_pkg::PH_LOW;
                        if (r_seen[pwm_dm_pkg::SEEN_LOW_BIT]) begin
                            n_stuck_lo = 1'b0;
                            n_stuck_hi = 1'b0;
                            n_seen     = '0;
                            n_ready    = 1'b1;
                        end
                    end else begin
                        n_seen     = '0;
                        n_stuck_hi = 1'b1;
                        n_ready    = 1'b1;
                    end
                end
                default: begin
                    n_low_w  = '0;
                    n_high_w = '0;
                    n_seen   = '0;
                    n_ready  = 1'b0;
                    n_phase  = i_pin_level ? pwm_dm_pkg::PH_HIGH : pwm_dm_pkg::PH_LOW;
                end
            endcase
        end else if (i_cmd.apply_item && (i_kind == pwm_dm_pkg::KIND_TIMEOUT)) begin
            n_stuck_hi = i_pin_level;
            n_stuck_lo = !i_pin_level;
            n_seen     = '0;
            n_ready    = 1'b1;
        end
        if (i_cmd.hist_wr) begin
            n_phase = pwm_dm_pkg::PH_UNKNOWN;
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pwm_dm_pkg::PH_UNKNOWN;
            r_seen      <= '0;
            r_low_w     <= '0;
            r_high_w    <= '0;
            r_stuck_lo  <= 1'b0;
            r_stuck_hi  <= 1'b0;
            r_ready     <= 1'b0;
            r_seeded    <= 1'b0;
            r_seed_item <= 1'b0;
            r_slot      <= '0;
            r_filt      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_seen     <= n_seen;
            r_low_w    <= n_low_w;
            r_high_w   <= n_high_w;
            r_stuck_lo <= n_stuck_lo;
            r_stuck_hi <= n_stuck_hi;
            r_ready    <= n_ready;

            if (i_cmd.apply_item) begin
                r_seed_item <= 1'b0;
            end
            if (i_cmd.seed_done) begin
                r_seeded    <= 1'b1;
                r_seed_item <= 1'b1;
                r_filt      <= seed_val;
            end
            if (i_cmd.trim_take) begin
                r_filt <= trim_prod[TRIM_S +: DW];
            end

            if (i_cmd.hist_wr) begin
                r_slot <= (r_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end

            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.seed_wr || i_cmd.walk_step) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_item) begin
            r_pin <= i_pin_level;
        end
        if (i_cmd.meas_take_fixed) begin
            if (r_stuck_hi) begin
                r_duty <= pwm_dm_pkg::FULL_SCALE;
            end else if (r_stuck_lo) begin
                r_duty <= '0;
            end else begin
                // both widths zero: seed value on the seeding item only
                r_duty <= r_seed_item ? seed_val : '0;
            end
        end else if (i_cmd.meas_take_div) begin
            r_duty <= div_quot[DW-1:0];
        end
        // read data for entry r_cnt-1 arrives while r_cnt is issued
        if (i_cmd.walk_step && (r_cnt != '0)) begin
            if (r_cnt == CW'(1)) begin
                r_tsum <= TSUM_W'(ram_rd_data);
                r_lo   <= ram_rd_data;
                r_hi   <= ram_rd_data;
            end else begin
                r_tsum <= r_tsum + TSUM_W'(ram_rd_data);
                if (ram_rd_data < r_lo) begin
                    r_lo <= ram_rd_data;
                end
                if (ram_rd_data > r_hi) begin
                    r_hi <= ram_rd_data;
                end
            end
        end
        if (i_cmd.trim_load) begin
            r_trim_sum <= trim_sum;
        end
        if (i_cmd.out_load) begin
            r_out_duty <= r_filt;
            r_out_pend <= r_ready;
        end
    end

    // history ring
    assign ram_wr_en   = i_cmd.seed_wr || i_cmd.hist_wr;
    assign ram_wr_addr = i_cmd.hist_wr ? r_slot : r_cnt[AW-1:0];
    assign ram_wr_data = i_cmd.hist_wr ? r_duty : seed_val;
    assign ram_rd_en   = i_cmd.walk_step && (r_cnt < CW'(HISTORY_DEPTH));

    pwm_dm_ram #(
        .WIDTH (DW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // trimmed mean: sum is registered, then scaled by the reciprocal
    assign trim_sum  = r_tsum - TSUM_W'(r_lo) - TSUM_W'(r_hi) + TSUM_W'(TRIM_N / 2);
    assign trim_prod = PROD_W'(r_trim_sum) * PROD_W'(TRIM_M);

    // serial divider for the measured duty
    assign meas_numer = pwm_dm_pkg::NUM_W'(r_high_w) * pwm_dm_pkg::NUM_W'(pwm_dm_pkg::FULL_SCALE)
                      + pwm_dm_pkg::NUM_W'(width_sum >> 1);

    pwm_dm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.meas_div_start),
        .i_numer (meas_numer),
        .i_denom (width_sum),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat           = '0;
        o_stat.seeded    = r_seeded;
        o_stat.ready     = r_ready;
        o_stat.stuck     = r_stuck_hi || r_stuck_lo;
        o_stat.sum_zero  = (width_sum == '0);
        o_stat.slot_last = (r_slot == AW'(HISTORY_DEPTH - 1));
        o_stat.cnt_last  = (r_cnt == CW'(HISTORY_DEPTH - 1));
        o_stat.walk_end  = (r_cnt == CW'(HISTORY_DEPTH));
        o_stat.div_done  = div_done;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid           = r_out_valid;
    assign o_duty_permille       = r_out_duty;
    assign o_measurement_pending = r_out_pend;

    `PDM_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, 1'b1, r_slot <= AW'(HISTORY_DEPTH - 1))
    `PDM_ASSERT_IMP(a_filt_range, i_clk, i_rst_n, 1'b1, r_filt <= pwm_dm_pkg::FULL_SCALE)
    `PDM_ASSERT_IMP(a_hist_after_seed, i_clk, i_rst_n, i_cmd.hist_wr, r_seeded)
    `PDM_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, i_cmd.meas_div_start, !div_busy)
    `PDM_ASSERT_NXT(a_pending_cleared, i_clk, i_rst_n, i_cmd.hist_wr, !r_ready)

endmodule
